### sv/psc_pkg.sv
// Shared types and constants of the pressure sensor compensation unit.
// Used by every module of the block but psc_checker; depends on nothing.
package psc_pkg;

   // Pipeline depth: register stages from request to response
   localparam int NUM_STAGES = 13;

   // Field widths
   localparam int RAW_W       = 24;
   localparam int COEF_W      = 16;
   localparam int CSR_INDEX_W = 3;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PRESSURE_SENS     = 3'd0,
      CSR_PRESSURE_OFFSET   = 3'd1,
      CSR_SENS_TEMP_COEFF   = 3'd2,
      CSR_OFFSET_TEMP_COEFF = 3'd3,
      CSR_REFERENCE_TEMP    = 3'd4,
      CSR_TEMP_SENS         = 3'd5,
      CSR_SURFACE_PRESSURE  = 3'd6
   } csr_index_type;

   localparam logic [COEF_W-1:0] SURFACE_PRESSURE_RESET = 16'd1013;

   // Reciprocals: ceil(2^32/100) for temperature, ceil(2^23/10) for pressure
   localparam logic [25:0] TC_RECIP = 26'd42949673;
   localparam logic [19:0] PR_RECIP = 20'd838861;

   // Depth factor 0.983615 in Q0.16
   localparam logic [16:0] DEPTH_FACTOR = 17'd64462;

   // Calibration words and surface pressure
   typedef struct packed {
      logic [COEF_W-1:0] pressure_sens;
      logic [COEF_W-1:0] pressure_offset;
      logic [COEF_W-1:0] sens_temp_coeff;
      logic [COEF_W-1:0] offset_temp_coeff;
      logic [COEF_W-1:0] reference_temp;
      logic [COEF_W-1:0] temp_sens;
      logic [COEF_W-1:0] surface_pressure;
   } coef_type;

   // Per-stage load enables from the pipeline control
   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
   } pipe_ctl_type;

   // Compensated terms handed from the front stages to the scaling stages
   typedef struct packed {
      logic [RAW_W-1:0]    d1;
      logic signed [37:0]  off;
      logic signed [37:0]  sens;
      logic [19:0]         tmag;
      logic                tc_neg;
   } comp_type;

endpackage

### sv/pressure_sensor_compensation_unit.sv
// Top level of the pressure sensor compensation unit: configuration registers
// and the pipeline. Depends on psc_pkg, psc_pipe_ctrl, psc_comp_stages and
// psc_scale_stages.
//
// Usage:
//   Write the six calibration words and the surface pressure through the csr_
//   port (index 0..6, write on csr_wr_en) while no request is in flight.
//   Each request on the req_ channel carries one raw pressure and one raw
//   temperature conversion; each produces one response on the rsp_ channel
//   with temperature in degrees C, pressure in mbar and depth.
//   Throughput: one request per clock cycle while req_stall is low.
//   A request passes from acceptance to rsp_valid through the thirteen
//   register stages of the multiply chain (dT products, deviation square,
//   split D1*SENS product, divide steps, depth scaling).
//   Reset clears all valid bits and returns the registers to their reset
//   values (surface pressure 1013, others 0).
//   When the receiver stalls, the response holds; stages behind it keep
//   filling empty slots, and req_stall rises only once the pipe is full.
module pressure_sensor_compensation_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [psc_pkg::RAW_W-1:0]        req_raw_pressure,
   input  logic [psc_pkg::RAW_W-1:0]        req_raw_temperature,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [7:0]                rsp_temperature_c,
   output logic [15:0]                      rsp_pressure_mbar,
   output logic signed [16:0]               rsp_depth_value,
   input  logic                             csr_wr_en,
   input  logic [psc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [psc_pkg::COEF_W-1:0]       csr_wdata
);
   import psc_pkg::*;

   coef_type     coef_ff, coef_in;
   pipe_ctl_type ctl;
   comp_type     comp;

   // Decode configuration writes; unknown indexes drop
   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PRESSURE_SENS:     coef_in.pressure_sens     = csr_wdata;
            CSR_PRESSURE_OFFSET:   coef_in.pressure_offset   = csr_wdata;
            CSR_SENS_TEMP_COEFF:   coef_in.sens_temp_coeff   = csr_wdata;
            CSR_OFFSET_TEMP_COEFF: coef_in.offset_temp_coeff = csr_wdata;
            CSR_REFERENCE_TEMP:    coef_in.reference_temp    = csr_wdata;
            CSR_TEMP_SENS:         coef_in.temp_sens         = csr_wdata;
            CSR_SURFACE_PRESSURE:  coef_in.surface_pressure  = csr_wdata;
            default: ;
         endcase
      end
   end

   // Clear the calibration words; surface pressure is the last field
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= {{(6*COEF_W){1'b0}}, SURFACE_PRESSURE_RESET};
      end else begin
         coef_ff <= coef_in;
      end
   end

   psc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   psc_comp_stages u_comp (
      .clock           (clock),
      .ctl             (ctl),
      .coef            (coef_ff),
      .raw_pressure    (req_raw_pressure),
      .raw_temperature (req_raw_temperature),
      .comp            (comp)
   );

   psc_scale_stages u_scale (
      .clock            (clock),
      .ctl              (ctl),
      .surface_pressure (coef_ff.surface_pressure),
      .comp             (comp),
      .temperature_c    (rsp_temperature_c),
      .pressure_mbar    (rsp_pressure_mbar),
      .depth_value      (rsp_depth_value)
   );

endmodule

### sv/psc_pipe_ctrl.sv
// Valid bits and load enables of the compensation pipeline.
// Depends on psc_pkg; a stage loads when it is empty or its successor moves.
module psc_pipe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  rsp_stall,
   output psc_pkg::pipe_ctl_type ctl,
   output logic                  req_stall,
   output logic                  rsp_valid
);
   import psc_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] hole;
   logic [NUM_STAGES-1:0] en;

   // Enable a stage when the output drains or it or any stage downstream of it is empty
   always_comb begin
      hole = ~valid_ff;
      for (int k = 0; k < NUM_STAGES; k++) begin
         en[k] = !rsp_stall || (|(hole >> k));
      end
   end

   // Advance valid bits with the data
   always_comb begin
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.en    = en;
   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

endmodule

### sv/psc_comp_stages.sv
// Stages 1 to 5: first-order compensation and second-order correction terms.
// Depends on psc_pkg; enables come from psc_pipe_ctrl.
module psc_comp_stages (
   input  logic                       clock,
   input  psc_pkg::pipe_ctl_type      ctl,
   input  psc_pkg::coef_type          coef,
   input  logic [psc_pkg::RAW_W-1:0]  raw_pressure,
   input  logic [psc_pkg::RAW_W-1:0]  raw_temperature,
   output psc_pkg::comp_type          comp
);
   import psc_pkg::*;

   localparam logic signed [41:0] BIAS_23 = 42'sd8388607;
   localparam logic signed [41:0] BIAS_7  = 42'sd127;
   localparam logic signed [41:0] BIAS_8  = 42'sd255;

   // Stage 1: dT
   logic signed [24:0] dt1_ff, dt1_in;
   logic [RAW_W-1:0]   d1_1_ff;

   assign dt1_in = $signed({1'b0, raw_temperature}) - $signed({1'b0, coef.reference_temp, 8'h00});

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         dt1_ff  <= dt1_in;
         d1_1_ff <= raw_pressure;
      end
   end

   // Stage 2: products of dT
   logic signed [41:0] tprod2_ff, tprod2_in;
   logic signed [41:0] oprod2_ff, oprod2_in;
   logic signed [41:0] sprod2_ff, sprod2_in;
   logic signed [49:0] dsq_full;
   logic [48:0]        dsq2_ff, dsq2_in;
   logic [RAW_W-1:0]   d1_2_ff;

   assign tprod2_in = dt1_ff * $signed({1'b0, coef.temp_sens});
   assign oprod2_in = dt1_ff * $signed({1'b0, coef.offset_temp_coeff});
   assign sprod2_in = dt1_ff * $signed({1'b0, coef.sens_temp_coeff});
   assign dsq_full  = dt1_ff * dt1_ff;
   assign dsq2_in   = dsq_full[48:0];

   always_ff @(posedge clock) begin
      if (ctl.en[1]) begin
         tprod2_ff <= tprod2_in;
         oprod2_ff <= oprod2_in;
         sprod2_ff <= sprod2_in;
         dsq2_ff   <= dsq2_in;
         d1_2_ff   <= d1_1_ff;
      end
   end

   // Stage 3: scale toward zero, form OFF, SENS and T2
   logic signed [41:0] tsum, osum, ssum;
   logic signed [34:0] oq;
   logic signed [33:0] sq;
   logic [49:0]        dsq3x;
   logic signed [18:0] q3_ff, q3_in;
   logic signed [36:0] off3_ff, off3_in;
   logic signed [36:0] sens3_ff, sens3_in;
   logic [16:0]        t2_3_ff, t2_3_in;
   logic [RAW_W-1:0]   d1_3_ff;

   always_comb begin
      tsum     = tprod2_ff + (tprod2_ff[41] ? BIAS_23 : 42'sd0);
      osum     = oprod2_ff + (oprod2_ff[41] ? BIAS_7 : 42'sd0);
      ssum     = sprod2_ff + (sprod2_ff[41] ? BIAS_8 : 42'sd0);
      q3_in    = tsum[41:23];
      oq       = osum[41:7];
      sq       = ssum[41:8];
      off3_in  = $signed({5'b0, coef.pressure_offset, 16'h0000})
               + $signed({{2{oq[34]}}, oq});
      sens3_in = $signed({6'b0, coef.pressure_sens, 15'h0000})
               + $signed({{3{sq[33]}}, sq});
      // Below 20.00 C: 3*dT^2/2^33, otherwise dT^2/2^36
      dsq3x    = {dsq2_ff, 1'b0} + {1'b0, dsq2_ff};
      t2_3_in  = q3_in[18] ? dsq3x[49:33] : {4'b0, dsq2_ff[48:36]};
   end

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         q3_ff    <= q3_in;
         off3_ff  <= off3_in;
         sens3_ff <= sens3_in;
         t2_3_ff  <= t2_3_in;
         d1_3_ff  <= d1_2_ff;
      end
   end

   // Stage 4: square of the temperature deviation, TEMP - T2
   logic signed [37:0] aux_full;
   logic [34:0]        aux4_ff, aux4_in;
   logic signed [19:0] tmt4_ff, tmt4_in;
   logic               low4_ff;
   logic signed [36:0] off4_ff, sens4_ff;
   logic [RAW_W-1:0]   d1_4_ff;

   assign aux_full = q3_ff * q3_ff;
   assign aux4_in  = aux_full[34:0];
   assign tmt4_in  = 20'sd2000 + $signed({q3_ff[18], q3_ff}) - $signed({3'b000, t2_3_ff});

   always_ff @(posedge clock) begin
      if (ctl.en[3]) begin
         aux4_ff  <= aux4_in;
         tmt4_ff  <= tmt4_in;
         low4_ff  <= q3_ff[18];
         off4_ff  <= off3_ff;
         sens4_ff <= sens3_ff;
         d1_4_ff  <= d1_3_ff;
      end
   end

   // Stage 5: apply OFF2 and SENS2, split temperature into magnitude and sign
   logic [36:0]        a3, a5;
   logic [35:0]        off2;
   logic [33:0]        sens2;
   logic signed [19:0] tmt_neg;
   comp_type           comp_ff, comp_in;

   always_comb begin
      a3      = {1'b0, aux4_ff, 1'b0} + {2'b00, aux4_ff};
      a5      = {aux4_ff, 2'b00} + {2'b00, aux4_ff};
      off2    = low4_ff ? a3[36:1] : {5'b0, aux4_ff[34:4]};
      sens2   = low4_ff ? a5[36:3] : 34'd0;
      tmt_neg = -tmt4_ff;
      comp_in.d1     = d1_4_ff;
      comp_in.off    = $signed({off4_ff[36], off4_ff}) - $signed({2'b00, off2});
      comp_in.sens   = $signed({sens4_ff[36], sens4_ff}) - $signed({4'b0000, sens2});
      comp_in.tmag   = tmt4_ff[19] ? tmt_neg : tmt4_ff;
      comp_in.tc_neg = tmt4_ff[19];
   end

   always_ff @(posedge clock) begin
      if (ctl.en[4]) begin
         comp_ff <= comp_in;
      end
   end

   assign comp = comp_ff;

endmodule

### sv/psc_scale_stages.sv
// Stages 6 to 13: pressure product and scaling, temperature and depth results.
// Depends on psc_pkg; takes the compensated terms of psc_comp_stages.
module psc_scale_stages (
   input  logic                        clock,
   input  psc_pkg::pipe_ctl_type       ctl,
   input  logic [psc_pkg::COEF_W-1:0]  surface_pressure,
   input  psc_pkg::comp_type           comp,
   output logic signed [7:0]           temperature_c,
   output logic [15:0]                 pressure_mbar,
   output logic signed [16:0]          depth_value
);
   import psc_pkg::*;

   localparam logic signed [62:0] BIAS_21  = 63'sd2097151;
   localparam logic signed [35:0] BIAS_16  = 36'sd65535;
   localparam logic signed [42:0] PR_SAT_Y = 43'sd5368709120;
   localparam logic [13:0]        TC_POS_LIMIT = 14'd127;
   localparam logic [13:0]        TC_NEG_LIMIT = 14'd128;
   localparam logic signed [7:0]  TC_MAX = 8'sd127;
   localparam logic signed [7:0]  TC_MIN = -8'sd128;

   // Stage 6: partial products of D1*SENS, temperature divide by 100
   logic [42:0]        pl6_ff, pl6_in;
   logic signed [43:0] ph6_ff, ph6_in;
   logic [45:0]        tprod;
   logic [13:0]        tq6_ff, tq6_in;
   logic               tcneg6_ff;
   logic signed [37:0] off6_ff;

   always_comb begin
      pl6_in = comp.d1 * comp.sens[18:0];
      ph6_in = $signed({1'b0, comp.d1}) * $signed(comp.sens[37:19]);
      tprod  = comp.tmag * TC_RECIP;
      tq6_in = tprod[45:32];
   end

   always_ff @(posedge clock) begin
      if (ctl.en[5]) begin
         pl6_ff    <= pl6_in;
         ph6_ff    <= ph6_in;
         tq6_ff    <= tq6_in;
         tcneg6_ff <= comp.tc_neg;
         off6_ff   <= comp.off;
      end
   end

   // Stage 7: join partial products, saturate temperature
   logic signed [62:0] p7_ff, p7_in;
   logic signed [7:0]  tc7_ff, tc7_in;
   logic signed [37:0] off7_ff;

   always_comb begin
      p7_in = $signed({ph6_ff, 19'b0}) + $signed({20'b0, pl6_ff});
      if (tcneg6_ff) begin
         tc7_in = (tq6_ff > TC_NEG_LIMIT) ? TC_MIN : $signed(8'd0 - tq6_ff[7:0]);
      end else begin
         tc7_in = (tq6_ff > TC_POS_LIMIT) ? TC_MAX : $signed(tq6_ff[7:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[6]) begin
         p7_ff   <= p7_in;
         tc7_ff  <= tc7_in;
         off7_ff <= off6_ff;
      end
   end

   // Stage 8: divide the product by 2^21 toward zero
   logic signed [62:0] pb;
   logic signed [41:0] pd8_ff, pd8_in;
   logic signed [7:0]  tc8_ff;
   logic signed [37:0] off8_ff;

   assign pb     = p7_ff + (p7_ff[62] ? BIAS_21 : 63'sd0);
   assign pd8_in = pb[62:21];

   always_ff @(posedge clock) begin
      if (ctl.en[7]) begin
         pd8_ff  <= pd8_in;
         tc8_ff  <= tc7_ff;
         off8_ff <= off7_ff;
      end
   end

   // Stage 9: subtract OFF
   logic signed [42:0] y9_ff, y9_in;
   logic signed [7:0]  tc9_ff;

   assign y9_in = $signed({pd8_ff[41], pd8_ff}) - $signed({{5{off8_ff[37]}}, off8_ff});

   always_ff @(posedge clock) begin
      if (ctl.en[8]) begin
         y9_ff  <= y9_in;
         tc9_ff <= tc8_ff;
      end
   end

   // Stage 10: divide by 81920 (shift by 13, then reciprocal of 10)
   logic [39:0]       pm;
   logic [16:0]       pq10_ff, pq10_in;
   logic              neg10_ff, neg10_in;
   logic              sat10_ff, sat10_in;
   logic signed [7:0] tc10_ff;

   always_comb begin
      neg10_in = y9_ff[42];
      sat10_in = !y9_ff[42] && (y9_ff >= PR_SAT_Y);
      pm       = y9_ff[32:13] * PR_RECIP;
      pq10_in  = pm[39:23];
   end

   always_ff @(posedge clock) begin
      if (ctl.en[9]) begin
         pq10_ff  <= pq10_in;
         neg10_ff <= neg10_in;
         sat10_ff <= sat10_in;
         tc10_ff  <= tc9_ff;
      end
   end

   // Stage 11: clamp pressure, form difference to surface pressure
   logic [15:0]        pr11_ff, pr11_in;
   logic signed [17:0] diff11_ff, diff11_in;
   logic signed [7:0]  tc11_ff;

   always_comb begin
      priority if (sat10_ff) begin
         pr11_in = 16'hFFFF;
      end else if (neg10_ff) begin
         pr11_in = 16'h0000;
      end else begin
         pr11_in = pq10_ff[15:0];
      end
      diff11_in = $signed({2'b00, pr11_in}) - $signed({2'b00, surface_pressure});
   end

   always_ff @(posedge clock) begin
      if (ctl.en[10]) begin
         pr11_ff   <= pr11_in;
         diff11_ff <= diff11_in;
         tc11_ff   <= tc10_ff;
      end
   end

   // Stage 12: scale by the depth factor
   logic signed [35:0] dm12_ff, dm12_in;
   logic [15:0]        pr12_ff;
   logic signed [7:0]  tc12_ff;

   assign dm12_in = diff11_ff * $signed({1'b0, DEPTH_FACTOR});

   always_ff @(posedge clock) begin
      if (ctl.en[11]) begin
         dm12_ff <= dm12_in;
         pr12_ff <= pr11_ff;
         tc12_ff <= tc11_ff;
      end
   end

   // Stage 13: divide by 2^16 toward zero into the output register;
   // the factor is below one, so depth stays inside its field range
   logic signed [35:0] db;
   logic signed [16:0] depth13_ff, depth13_in;
   logic [15:0]        pr13_ff;
   logic signed [7:0]  tc13_ff;

   assign db         = dm12_ff + (dm12_ff[35] ? BIAS_16 : 36'sd0);
   assign depth13_in = db[32:16];

   always_ff @(posedge clock) begin
      if (ctl.en[12]) begin
         depth13_ff <= depth13_in;
         pr13_ff    <= pr12_ff;
         tc13_ff    <= tc12_ff;
      end
   end

   assign temperature_c = tc13_ff;
   assign pressure_mbar = pr13_ff;
   assign depth_value   = depth13_ff;

endmodule

### sv/psc_checker.sv
// Port-level checks of the pressure sensor compensation unit and their bind.
// Depends on pressure_sensor_compensation_unit's port list only.
module psc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [7:0]  rsp_temperature_c,
   input logic [15:0]        rsp_pressure_mbar,
   input logic signed [16:0] rsp_depth_value
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         $stable({rsp_temperature_c, rsp_pressure_mbar, rsp_depth_value}))
      else $error("stalled response payload changed");

   // Never stall a request while the output side can drain
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("request stalled with the output free");

   // Depth is a scaled-down difference to a non-negative surface pressure
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_depth_value) <= $signed({1'b0, rsp_pressure_mbar}))
      else $error("depth exceeds pressure");

endmodule

bind pressure_sensor_compensation_unit psc_checker u_psc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_temperature_c (rsp_temperature_c),
   .rsp_pressure_mbar (rsp_pressure_mbar),
   .rsp_depth_value   (rsp_depth_value)
);

### verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for pressure_sensor_compensation_unit.
// Drives raw conversion pairs and calibration writes, predicts each compensated
// reading in 64-bit integer arithmetic and checks every response. Needs psc_pkg.
module tb;
   import psc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_CHUNKS  = 10;
   localparam int CHUNK_PAIRS    = 125;
   localparam longint DEPTH_Q16  = 64462;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   // Nominal calibration words of a typical part
   localparam int NOM_C1 = 34982;
   localparam int NOM_C2 = 36352;
   localparam int NOM_C3 = 20328;
   localparam int NOM_C4 = 22354;
   localparam int NOM_C5 = 26646;
   localparam int NOM_C6 = 26146;

   typedef enum logic [1:0] {
      STEP_PAIR,
      STEP_CSR,
      STEP_DRAIN,
      STEP_IDLE_MODE
   } step_kind_type;

   typedef struct packed {
      step_kind_type           kind;
      logic [RAW_W-1:0]        raw_p;
      logic [RAW_W-1:0]        raw_t;
      logic [CSR_INDEX_W-1:0]  idx;
      logic [COEF_W-1:0]       data;
      logic [6:0]              send_pct;
      logic [6:0]              recv_pct;
   } step_type;

   typedef struct packed {
      logic signed [7:0]  temperature_c;
      logic [15:0]        pressure_mbar;
      logic signed [16:0] depth_value;
   } reading_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [RAW_W-1:0]        req_raw_pressure = '0;
   logic [RAW_W-1:0]        req_raw_temperature = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [7:0]       rsp_temperature_c;
   logic [15:0]             rsp_pressure_mbar;
   logic signed [16:0]      rsp_depth_value;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [COEF_W-1:0]       csr_wdata = '0;

   step_type     conversion_queue[$];
   reading_type  reading_queue[$];
   coef_type     cfg;
   logic [15:0]  plan_c5;
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_stall_pct = 0;
   int           pairs_sent = 0;
   int           readings_checked = 0;
   int           settings_count = 0;
   int           mismatches = 0;
   int           idle_cycles = 0;

   pressure_sensor_compensation_unit uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_raw_pressure    (req_raw_pressure),
      .req_raw_temperature (req_raw_temperature),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_temperature_c   (rsp_temperature_c),
      .rsp_pressure_mbar   (rsp_pressure_mbar),
      .rsp_depth_value     (rsp_depth_value),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // First-order compensation, then the cold or warm second-order correction
   function automatic reading_type compensate_reading(input logic [RAW_W-1:0] raw_p,
                                                      input logic [RAW_W-1:0] raw_t);
      longint d1, d2, c1, c2, c3, c4, c5, c6, surf;
      longint dt, temp, off, sens, dev, sq, t2, off2, sens2, tc, pr, depth;
      reading_type r;
      d1   = {40'd0, raw_p};
      d2   = {40'd0, raw_t};
      c1   = {48'd0, cfg.pressure_sens};
      c2   = {48'd0, cfg.pressure_offset};
      c3   = {48'd0, cfg.sens_temp_coeff};
      c4   = {48'd0, cfg.offset_temp_coeff};
      c5   = {48'd0, cfg.reference_temp};
      c6   = {48'd0, cfg.temp_sens};
      surf = {48'd0, cfg.surface_pressure};

      dt   = d2 - c5 * 256;
      temp = 2000 + (dt * c6) / 8388608;
      off  = c2 * 65536 + (c4 * dt) / 128;
      sens = c1 * 32768 + (c3 * dt) / 256;

      dev = temp - 2000;
      sq  = dev * dev;
      if (temp < 2000) begin
         t2    = (3 * (dt * dt)) / 64'sd8589934592;
         off2  = (3 * sq) / 2;
         sens2 = (5 * sq) / 8;
      end else begin
         t2    = (2 * (dt * dt)) / 64'sd137438953472;
         off2  = sq / 16;
         sens2 = 0;
      end
      off  = off - off2;
      sens = sens - sens2;

      tc    = clamp((temp - t2) / 100, -128, 127);
      pr    = clamp((((d1 * sens) / 2097152 - off) / 8192) / 10, 0, 65535);
      depth = clamp(((pr - surf) * DEPTH_Q16) / 65536, -65536, 65535);

      r.temperature_c = tc[7:0];
      r.pressure_mbar = pr[15:0];
      r.depth_value   = depth[16:0];
      return r;
   endfunction

   // Mirror a register write into the local copy of the configuration
   task automatic apply_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [COEF_W-1:0] data);
      case (idx)
         CSR_PRESSURE_SENS:     cfg.pressure_sens     = data;
         CSR_PRESSURE_OFFSET:   cfg.pressure_offset   = data;
         CSR_SENS_TEMP_COEFF:   cfg.sens_temp_coeff   = data;
         CSR_OFFSET_TEMP_COEFF: cfg.offset_temp_coeff = data;
         CSR_REFERENCE_TEMP:    cfg.reference_temp    = data;
         CSR_TEMP_SENS:         cfg.temp_sens         = data;
         CSR_SURFACE_PRESSURE:  cfg.surface_pressure  = data;
         default: ;
      endcase
   endtask

   task automatic add_pair(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
      step_type s;
      s = '0;
      s.kind  = STEP_PAIR;
      s.raw_p = raw_p;
      s.raw_t = raw_t;
      conversion_queue.push_back(s);
   endtask

   task automatic add_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [COEF_W-1:0] data);
      step_type s;
      s = '0;
      s.kind = STEP_CSR;
      s.idx  = idx;
      s.data = data;
      conversion_queue.push_back(s);
   endtask

   task automatic add_step(input step_kind_type kind, input int send_pct, input int recv_pct);
      step_type s;
      s = '0;
      s.kind     = kind;
      s.send_pct = send_pct[6:0];
      s.recv_pct = recv_pct[6:0];
      conversion_queue.push_back(s);
   endtask

   task automatic add_coefs(input logic [15:0] c1, input logic [15:0] c2, input logic [15:0] c3,
                            input logic [15:0] c4, input logic [15:0] c5, input logic [15:0] c6,
                            input logic [15:0] surf);
      add_csr(CSR_PRESSURE_SENS, c1);
      add_csr(CSR_PRESSURE_OFFSET, c2);
      add_csr(CSR_SENS_TEMP_COEFF, c3);
      add_csr(CSR_OFFSET_TEMP_COEFF, c4);
      add_csr(CSR_REFERENCE_TEMP, c5);
      add_csr(CSR_TEMP_SENS, c6);
      add_csr(CSR_SURFACE_PRESSURE, surf);
      plan_c5 = c5;
      settings_count++;
   endtask

   function automatic logic [15:0] near(input int nominal);
      int v;
      v = nominal + int'($urandom_range(0, 8000)) - 4000;
      return v[15:0];
   endfunction

   // Raw temperature around the reference point, so both correction branches fire
   function automatic logic [RAW_W-1:0] plausible_raw_temp();
      longint t;
      t = longint'(plan_c5) * 256 + longint'($urandom_range(0, 6000000)) - 3000000;
      t = clamp(t, 0, 64'sd16777215);
      return t[RAW_W-1:0];
   endfunction

   // Driver: present requests, apply writes only with the pipe empty
   always @(posedge clock) begin
      step_type                s;
      logic                    nxt_valid;
      logic                    nxt_wr;
      logic [RAW_W-1:0]        nxt_p;
      logic [RAW_W-1:0]        nxt_t;
      logic [CSR_INDEX_W-1:0]  nxt_idx;
      logic [COEF_W-1:0]       nxt_data;
      nxt_valid = req_valid;
      nxt_p     = req_raw_pressure;
      nxt_t     = req_raw_temperature;
      nxt_wr    = 1'b0;
      nxt_idx   = csr_index;
      nxt_data  = csr_wdata;
      if (reset) begin
         nxt_valid = 1'b0;
         cfg = '0;
         cfg.surface_pressure = SURFACE_PRESSURE_RESET;
      end else begin
         if (req_valid && !req_stall) begin
            reading_queue.push_back(compensate_reading(req_raw_pressure, req_raw_temperature));
            pairs_sent++;
            nxt_valid = 1'b0;
         end
         if (!nxt_valid && conversion_queue.size() != 0) begin
            s = conversion_queue[0];
            case (s.kind)
               STEP_IDLE_MODE: begin
                  send_idle_pct  = {25'd0, s.send_pct};
                  recv_stall_pct = {25'd0, s.recv_pct};
                  void'(conversion_queue.pop_front());
               end
               STEP_CSR: begin
                  if (!req_valid && reading_queue.size() == 0) begin
                     nxt_wr   = 1'b1;
                     nxt_idx  = s.idx;
                     nxt_data = s.data;
                     apply_csr(s.idx, s.data);
                     void'(conversion_queue.pop_front());
                  end
               end
               STEP_DRAIN: begin
                  if (reading_queue.size() == 0) void'(conversion_queue.pop_front());
               end
               default: begin
                  if ($urandom_range(0, 99) >= send_idle_pct) begin
                     nxt_valid = 1'b1;
                     nxt_p     = s.raw_p;
                     nxt_t     = s.raw_t;
                     void'(conversion_queue.pop_front());
                  end
               end
            endcase
         end
      end
      req_valid           <= nxt_valid;
      req_raw_pressure    <= nxt_p;
      req_raw_temperature <= nxt_t;
      csr_wr_en           <= nxt_wr;
      csr_index           <= nxt_idx;
      csr_wdata           <= nxt_data;
   end

   // Monitor: compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (reading_queue.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = reading_queue.pop_front();
               if (rsp_temperature_c !== want.temperature_c)
                  report_mismatch($sformatf("temperature_c got %0d want %0d",
                                            rsp_temperature_c, want.temperature_c));
               if (rsp_pressure_mbar !== want.pressure_mbar)
                  report_mismatch($sformatf("pressure_mbar got %0d want %0d",
                                            rsp_pressure_mbar, want.pressure_mbar));
               if (rsp_depth_value !== want.depth_value)
                  report_mismatch($sformatf("depth_value got %0d want %0d",
                                            rsp_depth_value, want.depth_value));
               readings_checked++;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Watchdog: end the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int c5_raw;
      plan_c5 = '0;

      // Reset values: zero calibration, surface 1013
      add_step(STEP_IDLE_MODE, 38, 51);
      add_pair(24'h000000, 24'h000000);
      add_pair(24'hFFFFFF, 24'hFFFFFF);

      // Typical part: nominal point, field extremes, branch boundary
      add_coefs(16'(NOM_C1), 16'(NOM_C2), 16'(NOM_C3), 16'(NOM_C4), 16'(NOM_C5),
                16'(NOM_C6), 16'd1000);
      add_csr(CSR_UNUSED_INDEX, 16'hA5A5);
      c5_raw = NOM_C5 * 256;
      add_pair(24'd4958179, 24'd6815414);
      add_pair(24'd0, 24'd6815414);
      add_pair(24'hFFFFFF, 24'd6815414);
      add_pair(24'd4958179, 24'd0);
      add_pair(24'd4958179, 24'hFFFFFF);
      add_pair(24'd4958179, c5_raw[23:0]);
      add_pair(24'd4958179, c5_raw[23:0] - 24'd321);
      add_pair(24'h000000, 24'h000000);
      add_pair(24'hFFFFFF, 24'hFFFFFF);

      // All calibration words at maximum, surface at zero
      add_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
      add_pair(24'hFFFFFF, 24'hFFFFFF);
      add_pair(24'h000000, 24'h000000);
      add_pair(24'hFFFFFF, 24'h000000);
      add_pair(24'h000000, 24'hFFFFFF);
      add_pair(24'h800000, 24'h800000);

      // Zero calibration with surface at maximum: deepest negative depth
      add_coefs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      add_pair(24'd123456, 24'd654321);
      add_pair(24'hFFFFFF, 24'hFFFFFF);

      // Random chunks, each with its own calibration
      for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
         if (chunk == 4) add_step(STEP_IDLE_MODE, 51, 38);
         if (chunk == 7) add_step(STEP_IDLE_MODE, 0, 0);
         if (chunk == 3 || chunk == 6)
            add_coefs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom));
         else
            add_coefs(near(NOM_C1), near(NOM_C2), near(NOM_C3), near(NOM_C4),
                      near(NOM_C5), near(NOM_C6), 16'($urandom_range(900, 1100)));
         for (int i = 0; i < CHUNK_PAIRS; i++) begin
            if (chunk == 2 && i == 60) add_step(STEP_DRAIN, 0, 0);
            if ($urandom_range(0, 99) < 70)
               add_pair(24'($urandom_range(1000000, 10000000)), plausible_raw_temp());
            else
               add_pair(24'($urandom), 24'($urandom));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Hold until every request is out and every reading is back
      while (conversion_queue.size() != 0 || req_valid || reading_queue.size() != 0)
         @(posedge clock);
      repeat (NUM_STAGES + 4) @(posedge clock);

      $display("Sent %0d conversion pairs and checked %0d readings across %0d calibrations,",
               pairs_sent, readings_checked, settings_count);
      $display("with sender and receiver idling swapped, then idling off.");
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
